// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rate limiter RTL.
// Clocked, reset-qualified concurrent assertions; compiled out with NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- sv/lklrl_pkg.sv -----
// Shared types and constants for the keyed log rate limiter.
// No dependencies.
package lklrl_pkg;

   localparam int KEY_W        = 64;
   localparam int TIME_W       = 48;
   localparam int CAPACITY_DEF = 64;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [TIME_W-1:0] INTERVAL_RST = 48'd1000000;

   // register index, taken from the 8-byte aligned address
   localparam logic REG_REPEAT_INTERVAL = 1'b0;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic idx_clr;
      logic age_rd;
      logic log_rd;
      logic commit;
   } lklrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic idx_last;
      logic result;
   } lklrl_status_type;

endpackage

// ----- sv/lklrl_ctrl.sv -----
// Sequencing state machine for the rate limiter: scan pass, aging pass, commit.
// Depends on lklrl_pkg and assert_macros.svh; holds the result register.
`include "assert_macros.svh"

module lklrl_ctrl import lklrl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_log_permitted,
   output lklrl_cmd_type    cmd,
   input  lklrl_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_AGE,
      ST_AGE_DRAIN,
      ST_COMMIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_log_ff, rsp_log_in;
   logic      rsp_free;

   assign rsp_free          = !rsp_valid_ff || rsp_ready;
   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_log_permitted = rsp_log_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_log_in   = rsp_log_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.empty ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.idx_last) begin
               state_in = ST_SCAN_DRAIN;
            end
         end
         ST_SCAN_DRAIN: begin
            cmd.idx_clr = 1'b1;
            state_in    = ST_AGE;
         end
         ST_AGE: begin
            cmd.age_rd = 1'b1;
            if (status.idx_last) begin
               state_in = ST_AGE_DRAIN;
            end
         end
         ST_AGE_DRAIN: begin
            cmd.log_rd = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_log_in   = status.result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_log_ff <= rsp_log_in;
   end

   `ASSERT_RST(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside done state")
   `ASSERT_RST(a_accept_leaves_idle, clock, reset, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "accepted transaction left controller idle")
   `ASSERT_RST(a_commit_order, clock, reset, (state_ff == ST_COMMIT) |-> ($past(state_ff) == ST_AGE_DRAIN || $past(state_ff) == ST_IDLE), "commit reached out of order")

endmodule

// ----- sv/lklrl_dpath.sv -----
// Datapath for the rate limiter: key, last-log and rank memories, fill count,
// scan/age address counter, hit and eviction tracking. Depends on lklrl_pkg.
`include "assert_macros.svh"

module lklrl_dpath import lklrl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lklrl_cmd_type     cmd,
   output lklrl_status_type  status,
   input  logic [KEY_W-1:0]  req_event_key,
   input  logic [TIME_W-1:0] req_now_time,
   input  logic [TIME_W-1:0] repeat_interval
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

   logic [KEY_W-1:0]  key_mem  [CAPACITY];
   logic [TIME_W-1:0] last_mem [CAPACITY];
   logic [IW-1:0]     rank_mem [CAPACITY];

   logic [KEY_W-1:0]  key_ff, key_in, key_q_ff;
   logic [TIME_W-1:0] now_ff, now_in, last_q_ff;
   logic [IW-1:0]     rank_q_ff;
   logic [IW-1:0]     idx_ff, idx_in, rd_idx_ff;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in, hit_rank_ff, hit_rank_in;
   logic [IW-1:0]     old_idx_ff, old_idx_in;
   logic              rd_v_ff, rd_age_ff;
   logic              hit_ff, hit_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              result_ff, result_in;

   logic [CW-1:0]     fill_m1;
   logic              full, scan_v, age_v, key_match, age_we, due;
   logic [TIME_W-1:0] elapsed;
   logic [IW-1:0]     ins_slot;
   logic              slot_we, last_we, rank_we;
   logic [IW-1:0]     last_waddr, rank_waddr, rank_wdata;

   assign fill_m1   = fill_ff - CW'(1);
   assign full      = (fill_ff == FULL_CNT);
   assign scan_v    = rd_v_ff && !rd_age_ff;
   assign age_v     = rd_v_ff && rd_age_ff;
   assign key_match = (key_q_ff == key_ff);
   assign age_we    = age_v && (!hit_ff || (rank_q_ff < hit_rank_ff));
   assign elapsed   = now_ff - last_q_ff;
   assign due       = (elapsed >= repeat_interval);
   assign ins_slot  = full ? old_idx_ff : fill_ff[IW-1:0];

   assign slot_we    = cmd.commit && !hit_ff;
   assign last_we    = cmd.commit && (!hit_ff || due);
   assign last_waddr = hit_ff ? hit_idx_ff : ins_slot;
   assign rank_we    = age_we || cmd.commit;
   assign rank_waddr = age_we ? rd_idx_ff : last_waddr;
   assign rank_wdata = age_we ? IW'(rank_q_ff + IW'(1)) : '0;

   assign status.empty    = (fill_ff == '0);
   assign status.idx_last = (CW'(idx_ff) == fill_m1);
   assign status.result   = result_ff;

   always_comb begin
      key_in      = key_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      old_idx_in  = old_idx_ff;
      fill_in     = fill_ff;
      result_in   = result_ff;
      if (cmd.load) begin
         key_in = req_event_key;
         now_in = req_now_time;
         idx_in = '0;
         hit_in = 1'b0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.scan_rd || cmd.age_rd) begin
         idx_in = IW'(idx_ff + IW'(1));
      end
      if (scan_v && !hit_ff && key_match) begin
         hit_in      = 1'b1;
         hit_idx_in  = rd_idx_ff;
         hit_rank_in = rank_q_ff;
      end
      // the highest rank among valid slots is fill-1
      if (scan_v && (CW'(rank_q_ff) == fill_m1)) begin
         old_idx_in = rd_idx_ff;
      end
      if (cmd.commit) begin
         result_in = hit_ff ? due : 1'b1;
         if (!hit_ff && !full) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         hit_ff    <= 1'b0;
         fill_ff   <= '0;
         rd_v_ff   <= 1'b0;
         rd_age_ff <= 1'b0;
         result_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         hit_ff    <= hit_in;
         fill_ff   <= fill_in;
         rd_v_ff   <= cmd.scan_rd || cmd.age_rd;
         rd_age_ff <= cmd.age_rd;
         result_ff <= result_in;
      end
      key_ff      <= key_in;
      now_ff      <= now_in;
      rd_idx_ff   <= idx_ff;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      old_idx_ff  <= old_idx_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_mem[ins_slot] <= key_ff;
      end
      if (cmd.scan_rd || cmd.age_rd) begin
         key_q_ff <= key_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      if (cmd.scan_rd || cmd.age_rd) begin
         rank_q_ff <= rank_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (last_we) begin
         last_mem[last_waddr] <= now_ff;
      end
      if (cmd.log_rd) begin
         last_q_ff <= last_mem[hit_idx_ff];
      end
   end

   `ASSERT_RST(a_fill_bound, clock, reset, fill_ff <= FULL_CNT, "fill count beyond capacity")
   `ASSERT_NEVER(a_rank_port, clock, reset, age_we && cmd.commit, "aging write collides with commit")
   `ASSERT_RST(a_fill_grow, clock, reset, (cmd.commit && !hit_ff && !full) |=> (fill_ff == $past(fill_ff) + CW'(1)), "insert into free slot did not grow table")

endmodule

// ----- sv/lru_keyed_log_rate_limiter_core.sv -----
// Keyed log rate limiter with least-recently-observed table; one result per transaction.
// Each transaction runs a key/rank scan pass and a rank aging pass over the F entries in
// use (F = 1..CAPACITY), skipped on an empty table, then a commit; a new transaction is
// accepted only once the previous result has been handed to rsp_valid.
// Synchronous active-high reset: empty table, no pending result, interval = 1000000.
module lru_keyed_log_rate_limiter_core import lklrl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KEY_W-1:0]      req_event_key,
   input  logic [TIME_W-1:0]     req_now_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_log_permitted,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   lklrl_cmd_type    cmd;
   lklrl_status_type status;
   logic [TIME_W-1:0] interval_ff, interval_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      interval_in = interval_ff;
      csr_prdata  = '0;
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_REPEAT_INTERVAL: begin
            csr_prdata = CSR_DATA_W'(interval_ff);
            if (csr_wr) begin
               interval_in = csr_pwdata[TIME_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RST;
      end else begin
         interval_ff <= interval_in;
      end
   end

   lklrl_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_log_permitted (rsp_log_permitted),
      .cmd               (cmd),
      .status            (status)
   );

   lklrl_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_event_key   (req_event_key),
      .req_now_time    (req_now_time),
      .repeat_interval (interval_ff)
   );

endmodule

// ----- sim/rate_limit_checker.sv -----
`timescale 1ns / 1ps
// Checker for lru_keyed_log_rate_limiter_core: mirrors the key table and the interval
// register, predicts the log decision per accepted transaction and compares responses.
// Depends on lklrl_pkg.
module rate_limit_checker import lklrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [KEY_W-1:0]      req_event_key,
   input  logic [TIME_W-1:0]     req_now_time,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_log_permitted,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_cnt,
   output int                    open_cnt
);

   localparam int SLOTS = CAPACITY_DEF;

   logic [KEY_W-1:0]  slot_id    [SLOTS];
   logic [TIME_W-1:0] slot_stamp [SLOTS];
   bit                slot_used  [SLOTS];
   int unsigned       slot_age   [SLOTS];
   logic [TIME_W-1:0] min_gap;
   bit                permit_q[$];

   initial begin
      fail_cnt = 0;
      open_cnt = 0;
   end

   // age every live entry that is more recent than limit
   function automatic void bump_ages(input int unsigned limit);
      int i;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && slot_age[i] < limit)
            slot_age[i]++;
      end
   endfunction

   function automatic bit log_decision(input logic [KEY_W-1:0] key,
                                       input logic [TIME_W-1:0] now);
      int i, hit, vacant, victim;
      int unsigned victim_age;
      logic [TIME_W-1:0] since;
      bit due;
      hit = -1;
      vacant = -1;
      victim = -1;
      victim_age = 0;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_id[i] == key)
               hit = i;
            if (victim < 0 || slot_age[i] > victim_age) begin
               victim = i;
               victim_age = slot_age[i];
            end
         end else if (vacant < 0) begin
            vacant = i;
         end
      end
      if (hit >= 0) begin
         bump_ages(slot_age[hit]);
         slot_age[hit] = 0;
         since = now - slot_stamp[hit];
         due = (since >= min_gap);
         if (due)
            slot_stamp[hit] = now;
         return due;
      end
      // table full: reuse the least recently observed slot
      if (vacant < 0) begin
         vacant = (victim >= 0) ? victim : 0;
         slot_used[vacant] = 1'b0;
      end
      bump_ages(32'hFFFF_FFFF);
      slot_used[vacant]  = 1'b1;
      slot_id[vacant]    = key;
      slot_stamp[vacant] = now;
      slot_age[vacant]   = 0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      bit want;
      int i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
         end
         min_gap = INTERVAL_RST;
         permit_q.delete();
         open_cnt <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (permit_q.size() == 0) begin
               if (fail_cnt < 10)
                  $display("%0t: response with no transaction pending, log_permitted=%b",
                           $time, rsp_log_permitted);
               fail_cnt++;
            end else begin
               want = permit_q.pop_front();
               if (rsp_log_permitted !== want) begin
                  if (fail_cnt < 10)
                     $display("%0t: log_permitted mismatch, expected %b, got %b",
                              $time, want, rsp_log_permitted);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && req_ready)
            permit_q.insert(permit_q.size(), log_decision(req_event_key, req_now_time));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:3] == REG_REPEAT_INTERVAL)
            min_gap = csr_pwdata[TIME_W-1:0];
         open_cnt <= permit_q.size();
      end
   end

endmodule

// ----- sim/tb_lru_keyed_log_rate_limiter_core.sv -----
`timescale 1ns / 1ps
// Testbench top for lru_keyed_log_rate_limiter_core: clock, reset, event and register
// stimulus, response backpressure and verdict. Depends on lklrl_pkg and rate_limit_checker.
module tb_lru_keyed_log_rate_limiter_core;
   import lklrl_pkg::*;

   localparam int HOLD_CYCLES = 500;
   localparam int TAIL_CYCLES = 150;
   localparam int LIMIT       = 2000000;
   localparam int POOL        = 100;
   localparam int HOT         = 40;
   localparam int PHASE_ITEMS = 300;
   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR =
      CSR_ADDR_W'(REG_REPEAT_INTERVAL) << 3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KEY_W-1:0]      req_event_key = '0;
   logic [TIME_W-1:0]     req_now_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_log_permitted;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_cnt;
   int open_cnt;
   int cycle_cnt = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left;
   logic hold_req = 1'b0;
   logic hold_seen;

   logic [KEY_W-1:0] key_pool [POOL];

   always #10 clock = ~clock;

   lru_keyed_log_rate_limiter_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_event_key     (req_event_key),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_log_permitted (rsp_log_permitted),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   rate_limit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_event_key     (req_event_key),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_log_permitted (rsp_log_permitted),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_cnt          (fail_cnt),
      .open_cnt          (open_cnt)
   );

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response backpressure; a toggle of hold_req starts a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_event_key <= key;
      req_now_time  <= now;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_cnt != 0)
         @(posedge clock);
   endtask

   // upper bits beyond the 48-bit register carry noise
   task automatic write_interval(input logic [TIME_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom, $urandom};
      word[TIME_W-1:0] = value;
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= INTERVAL_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [TIME_W-1:0] interval_set [6];
      int unsigned       step_set [6];
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now_cursor;
      logic [TIME_W-1:0] now;
      int pick, s, n;

      interval_set = '{48'd1000, 48'd0, 48'd300, TIME_MAX, 48'd5000, 48'd40000};
      step_set     = '{60, 25, 20, 3000, 300, 2000};
      for (n = 0; n < POOL; n++)
         key_pool[n] = {$urandom, $urandom};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset interval, wrap, clock going backwards
      send_event('0, '0);
      send_event('1, TIME_MAX);
      send_event('0, 48'd999999);
      send_event('0, 48'd1000000);
      send_event('1, 48'd999998);
      send_event('0, 48'd10);
      send_event('0, 48'd11);
      // zero interval
      write_interval('0);
      send_event('0, 48'd11);
      send_event('1, 48'd999998);
      // largest interval
      write_interval(TIME_MAX);
      send_event('0, 48'd12);
      send_event('0, 48'd10);
      send_event(64'h8000_0000_0000_0001, 48'h8000_0000_0000);
      send_event(64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      send_event(64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555);
      write_interval(INTERVAL_RST);
      send_event(64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA);

      now_cursor = 48'd5000;
      for (s = 0; s < 6; s++) begin
         write_interval(interval_set[s]);
         send_idle_pct = (s < 2) ? 33 : (s < 4) ? 55 : 0;
         rsp_idle_pct  = (s < 2) ? 55 : (s < 4) ? 33 : 0;
         if (s == 4)
            now_cursor = 48'hFFFF_FFFF_C000;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (s == 1 && n == 100)
               hold_req <= ~hold_req;
            if (s == 3 && n == 150)
               drain();
            pick = $urandom_range(99);
            if (pick < 60)
               key = key_pool[$urandom_range(HOT - 1)];
            else if (pick < 95)
               key = key_pool[$urandom_range(POOL - 1)];
            else
               key = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick == 0) begin
               now = TIME_W'({$urandom, $urandom});
            end else begin
               if (pick == 1)
                  now_cursor = now_cursor - TIME_W'($urandom_range(step_set[s] * 40));
               else
                  now_cursor = now_cursor + TIME_W'($urandom_range(step_set[s]));
               now = now_cursor;
            end
            send_event(key, now);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_cnt == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lklrl_pkg.sv
sv/lklrl_ctrl.sv
sv/lklrl_dpath.sv
sv/lru_keyed_log_rate_limiter_core.sv
sim/rate_limit_checker.sv
sim/tb_lru_keyed_log_rate_limiter_core.sv
